### rtl/kpt_pkg.sv
// Shared constants, types and helpers for the keyed presence table.
package kpt_pkg;

    // Table geometry.
    localparam int TABLE_SLOTS = 16;
    localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);

    // Field widths.
    localparam int KEY_W  = 64;
    localparam int ADDR_W = 32;
    localparam int TIME_W = 48;
    localparam int TTL_W  = 32;
    localparam int OCNT_W = 5;
    localparam int OIDX_W = 4;

    localparam logic [TTL_W-1:0] TTL_DEFAULT = TTL_W'(30000);

    // Request type codes.
    localparam logic REQ_SYNC   = 1'b0;
    localparam logic REQ_EXPIRE = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_MALFORMED = 2'd1,
        STAT_FULL      = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    // Captured request payload.
    typedef struct packed {
        logic [KEY_W-1:0]  room;
        logic [KEY_W-1:0]  dev;
        logic [ADDR_W-1:0] link;
        logic              online;
        logic [TIME_W-1:0] now;
    } t_req;

    // One table entry as seen on the read port.
    typedef struct packed {
        logic              used;
        logic              online;
        logic [KEY_W-1:0]  room;
        logic [KEY_W-1:0]  dev;
        logic [ADDR_W-1:0] link;
        logic [TIME_W-1:0] last;
        logic [TTL_W-1:0]  ttl;
    } t_entry;

    // Per-slot verdict of the compare unit.
    typedef struct packed {
        logic key_hit;
        logic differs;
        logic stale;
    } t_slot_res;

    // Table access commands from the sequencer.
    typedef struct packed {
        logic              wr_en;
        logic              clr_en;
        logic [SLOT_W-1:0] rd_idx;
        logic [SLOT_W-1:0] wr_idx;
    } t_store_cmd;

    // Saturate an internal count to the width of the result field.
    function automatic logic [OCNT_W-1:0] sat_count(input logic [CNT_W-1:0] cnt);
        logic [CNT_W+OCNT_W-1:0] ext;
        ext = {{OCNT_W{1'b0}}, cnt};
        if (ext > (CNT_W + OCNT_W)'({OCNT_W{1'b1}})) begin
            return {OCNT_W{1'b1}};
        end
        return ext[OCNT_W-1:0];
    endfunction

endpackage

### rtl/kpt_store.sv
// Entry table: per-slot registers with occupied and online flags.
module kpt_store
    import kpt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_store_cmd       i_cmd,
    input  t_req             i_req,
    input  logic [TTL_W-1:0] i_eff_ttl,
    output t_entry           o_ent
);

    logic [TABLE_SLOTS-1:0] r_used;
    logic [TABLE_SLOTS-1:0] r_online;
    logic [KEY_W-1:0]       r_room [TABLE_SLOTS];
    logic [KEY_W-1:0]       r_dev  [TABLE_SLOTS];
    logic [ADDR_W-1:0]      r_link [TABLE_SLOTS];
    logic [TIME_W-1:0]      r_last [TABLE_SLOTS];
    logic [TTL_W-1:0]       r_ttl  [TABLE_SLOTS];

    // Flags are cleared by reset; a sync sets used and writes online from the request, an expiry clears online.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= '0;
            r_online <= '0;
        end else begin
            if (i_cmd.clr_en) begin
                r_online[i_cmd.rd_idx] <= 1'b0;
            end
            if (i_cmd.wr_en) begin
                r_used[i_cmd.wr_idx]   <= 1'b1;
                r_online[i_cmd.wr_idx] <= i_req.online;
            end
        end
    end

    // Entry payload is only read for occupied slots.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_room[i_cmd.wr_idx] <= i_req.room;
            r_dev[i_cmd.wr_idx]  <= i_req.dev;
            r_link[i_cmd.wr_idx] <= i_req.link;
            r_last[i_cmd.wr_idx] <= i_req.now;
            r_ttl[i_cmd.wr_idx]  <= i_eff_ttl;
        end
    end

    // Single read port at the scan position.
    always_comb begin
        o_ent.used   = r_used[i_cmd.rd_idx];
        o_ent.online = r_online[i_cmd.rd_idx];
        o_ent.room   = r_room[i_cmd.rd_idx];
        o_ent.dev    = r_dev[i_cmd.rd_idx];
        o_ent.link   = r_link[i_cmd.rd_idx];
        o_ent.last   = r_last[i_cmd.rd_idx];
        o_ent.ttl    = r_ttl[i_cmd.rd_idx];
    end

endmodule

### rtl/kpt_slot_unit.sv
// Shared compare unit: key match, content difference and age check for one slot.
module kpt_slot_unit
    import kpt_pkg::*;
(
    input  t_entry           i_ent,
    input  t_req             i_req,
    input  logic [TTL_W-1:0] i_eff_ttl,
    output t_slot_res        o_res
);

    logic [TIME_W:0]   w_age;
    logic [TTL_W-1:0]  w_ttl;
    logic              w_not_future;

    // Age with borrow; a last-seen time in the future never expires.
    assign w_age        = {1'b0, i_req.now} - {1'b0, i_ent.last};
    assign w_not_future = !w_age[TIME_W];
    assign w_ttl        = (i_ent.ttl != '0) ? i_ent.ttl : i_eff_ttl;

    always_comb begin
        o_res.key_hit = i_ent.used && (i_ent.room == i_req.room);
        o_res.differs = (i_ent.dev != i_req.dev) || (i_ent.link != i_req.link) ||
                        (i_ent.online != i_req.online);
        o_res.stale   = i_ent.used && i_ent.online && w_not_future &&
                        (w_age[TIME_W-1:0] > TIME_W'(w_ttl));
    end

endmodule

### rtl/keyed_presence_table_with_aging_top.sv
// Flow: a malformed sync skips the scan and goes from the FINISH state straight to the
// result register; any other request scans one slot per cycle, up to TABLE_SLOTS slots.
// A new request is taken only when the previous one is finished, as the single compare
// unit steps through the table; a result that is not taken holds the block in FINISH.
// Reset (synchronous, active low) empties the table, zeroes both counts, sets the TTL
// register to 30000 and leaves the block ready; no clearing pass is needed.
module keyed_presence_table_with_aging_top
    import kpt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Request channel.
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_req_type,
    input  logic              i_well_formed,
    input  logic [KEY_W-1:0]  i_room_key,
    input  logic [KEY_W-1:0]  i_device_key,
    input  logic [ADDR_W-1:0] i_link_addr,
    input  logic              i_online_in,
    input  logic [TIME_W-1:0] i_now_ms,
    // Result channel.
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_ack_ok,
    output logic [1:0]        o_status,
    output logic              o_changed,
    output logic [OIDX_W-1:0] o_slot_index,
    output logic [OCNT_W-1:0] o_occupied_count,
    output logic [OCNT_W-1:0] o_online_count,
    // Configuration channel.
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [TTL_W-1:0]  i_cfg_ttl_ms
);

    t_state            r_state, n_state;
    logic [TTL_W-1:0]  r_ttl;
    logic [TTL_W-1:0]  w_eff_ttl;
    t_req              r_req;
    logic              r_req_type;
    logic              r_bad;
    logic [SLOT_W-1:0] r_idx;
    logic              r_found;
    logic [SLOT_W-1:0] r_hit_idx;
    logic              r_hit_onl;
    logic              r_chg;
    logic              r_free_vld;
    logic [SLOT_W-1:0] r_free_idx;
    logic              r_exp_chg;
    logic [CNT_W-1:0]  r_occ;
    logic [CNT_W-1:0]  r_onl;

    logic              r_out_valid;
    logic              r_ack;
    t_status           r_status;
    logic              r_chg_o;
    logic [OIDX_W-1:0] r_slot_o;
    logic [OCNT_W-1:0] r_occ_o;
    logic [OCNT_W-1:0] r_onl_o;

    logic              w_in_fire;
    logic              w_last;
    logic              w_out_free;
    logic              w_fin_fire;
    logic              w_is_sync;
    logic              w_have_slot;
    logic              w_ack;
    logic [SLOT_W-1:0] w_tgt_idx;
    logic [SLOT_W+OIDX_W-1:0] w_tgt_ext;
    logic [CNT_W-1:0]  w_occ_n;
    logic [CNT_W-1:0]  w_onl_n;
    t_store_cmd        w_cmd;
    t_entry            w_ent;
    t_slot_res         w_res;

    // Table and compare unit.
    kpt_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_req     (r_req),
        .i_eff_ttl (w_eff_ttl),
        .o_ent     (w_ent)
    );

    kpt_slot_unit u_unit (
        .i_ent     (w_ent),
        .i_req     (r_req),
        .i_eff_ttl (w_eff_ttl),
        .o_res     (w_res)
    );

    // TTL register; a zero value falls back to the default.
    assign o_cfg_ready = 1'b1;
    assign w_eff_ttl   = (r_ttl != '0) ? r_ttl : TTL_DEFAULT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ttl <= TTL_DEFAULT;
        end else if (i_cfg_valid) begin
            r_ttl <= i_cfg_ttl_ms;
        end
    end

    // Handshake and scan bookkeeping.
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign w_last      = (r_idx == SLOT_W'(TABLE_SLOTS - 1));
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_fin_fire  = (r_state == ST_FINISH) && w_out_free;
    assign w_is_sync   = (r_req_type == REQ_SYNC);
    assign w_have_slot = r_found || r_free_vld;
    assign w_ack       = w_is_sync && !r_bad && w_have_slot;
    assign w_tgt_idx   = r_found ? r_hit_idx : r_free_idx;
    assign w_tgt_ext   = {{OIDX_W{1'b0}}, w_tgt_idx};

    // Table commands: write on a successful sync, clear online on a stale entry.
    always_comb begin
        w_cmd.rd_idx = r_idx;
        w_cmd.wr_idx = w_tgt_idx;
        w_cmd.wr_en  = w_fin_fire && w_ack;
        w_cmd.clr_en = (r_state == ST_SCAN) && !w_is_sync && w_res.stale;
    end

    // Occupancy and online counts after this cycle's table updates.
    assign w_occ_n = r_occ + CNT_W'(w_cmd.wr_en && !r_found);
    assign w_onl_n = r_onl - CNT_W'(w_cmd.clr_en)
                   - CNT_W'(w_cmd.wr_en && r_found && r_hit_onl)
                   + CNT_W'(w_cmd.wr_en && r_req.online);

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and ready.
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if ((i_req_type == REQ_SYNC) && (!i_well_formed ||
                        (i_room_key == '0) || (i_device_key == '0))) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (w_last || (w_is_sync && w_res.key_hit)) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_req.room   <= i_room_key;
            r_req.dev    <= i_device_key;
            r_req.link   <= i_link_addr;
            r_req.online <= i_online_in;
            r_req.now    <= i_now_ms;
            r_req_type   <= i_req_type;
        end
    end

    // Scan control: match, first free slot and expiry tracking.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bad      <= 1'b0;
            r_idx      <= '0;
            r_found    <= 1'b0;
            r_hit_idx  <= '0;
            r_hit_onl  <= 1'b0;
            r_chg      <= 1'b0;
            r_free_vld <= 1'b0;
            r_free_idx <= '0;
            r_exp_chg  <= 1'b0;
            r_occ      <= '0;
            r_onl      <= '0;
        end else begin
            r_occ <= w_occ_n;
            r_onl <= w_onl_n;
            if (w_in_fire) begin
                r_bad      <= (i_req_type == REQ_SYNC) && (!i_well_formed ||
                              (i_room_key == '0) || (i_device_key == '0));
                r_idx      <= '0;
                r_found    <= 1'b0;
                r_free_vld <= 1'b0;
                r_exp_chg  <= 1'b0;
            end else if (r_state == ST_SCAN) begin
                r_idx <= r_idx + SLOT_W'(1);
                if (w_is_sync) begin
                    if (w_res.key_hit) begin
                        r_found   <= 1'b1;
                        r_hit_idx <= r_idx;
                        r_hit_onl <= w_ent.online;
                        r_chg     <= w_res.differs;
                    end else if (!w_ent.used && !r_free_vld) begin
                        r_free_vld <= 1'b1;
                        r_free_idx <= r_idx;
                    end
                end else if (w_res.stale) begin
                    r_exp_chg <= 1'b1;
                end
            end
        end
    end

    // Result register: holds one finished result until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fin_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin_fire) begin
            r_ack    <= w_ack;
            r_occ_o  <= sat_count(w_occ_n);
            r_onl_o  <= sat_count(w_onl_n);
            r_slot_o <= w_ack ? w_tgt_ext[OIDX_W-1:0] : '0;
            if (!w_is_sync) begin
                r_status <= STAT_OK;
                r_chg_o  <= r_exp_chg;
            end else if (r_bad) begin
                r_status <= STAT_MALFORMED;
                r_chg_o  <= 1'b0;
            end else if (!w_have_slot) begin
                r_status <= STAT_FULL;
                r_chg_o  <= 1'b0;
            end else begin
                r_status <= STAT_OK;
                r_chg_o  <= r_found ? r_chg : 1'b1;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_ack_ok         = r_ack;
    assign o_status         = r_status;
    assign o_changed        = r_chg_o;
    assign o_slot_index     = r_slot_o;
    assign o_occupied_count = r_occ_o;
    assign o_online_count   = r_onl_o;

`ifndef SYNTHESIS
    // Online entries are a subset of occupied entries.
    a_onl_le_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_onl <= r_occ)
        else $error("online count exceeds occupied count");

    // The occupied count never passes the table size.
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CNT_W'(TABLE_SLOTS))
        else $error("occupied count exceeds table size");

    // A table write always targets a matched or a free slot.
    a_wr_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.wr_en |-> (r_found || r_free_vld))
        else $error("table write without a target slot");

    // A malformed sync skips the scan.
    a_bad_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && (i_req_type == REQ_SYNC) && !i_well_formed)
        |=> (r_state == ST_FINISH))
        else $error("malformed sync entered the scan");
`endif

endmodule

### sim/presence_table_checker.sv
// Checker for the keyed presence table: watches all three channels, predicts and compares replies.
`timescale 1ns / 1ps

module presence_table_checker
    import kpt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Request channel.
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic              i_req_type,
    input  logic              i_well_formed,
    input  logic [KEY_W-1:0]  i_room_key,
    input  logic [KEY_W-1:0]  i_device_key,
    input  logic [ADDR_W-1:0] i_link_addr,
    input  logic              i_online_in,
    input  logic [TIME_W-1:0] i_now_ms,
    // Result channel.
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic              i_ack_ok,
    input  logic [1:0]        i_status,
    input  logic              i_changed,
    input  logic [OIDX_W-1:0] i_slot_index,
    input  logic [OCNT_W-1:0] i_occupied_count,
    input  logic [OCNT_W-1:0] i_online_count,
    // Configuration channel.
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [TTL_W-1:0]  i_cfg_ttl_ms,
    // Verdict inputs for the testbench top.
    output int                o_fail_count,
    output int                o_replies_pending
);

    // One acknowledgement as the block should return it.
    typedef struct packed {
        logic              ack_ok;
        t_status           status;
        logic              changed;
        logic [OIDX_W-1:0] slot_index;
        logic [OCNT_W-1:0] occupied_count;
        logic [OCNT_W-1:0] online_count;
    } t_presence_ack;

    // Shadow copy of the register and the room table.
    logic [TTL_W-1:0]  ttl_reg;
    logic              used_q     [TABLE_SLOTS];
    logic [KEY_W-1:0]  room_q     [TABLE_SLOTS];
    logic [KEY_W-1:0]  dev_q      [TABLE_SLOTS];
    logic [ADDR_W-1:0] link_q     [TABLE_SLOTS];
    logic              online_q   [TABLE_SLOTS];
    logic [TIME_W-1:0] last_q     [TABLE_SLOTS];
    logic [TTL_W-1:0]  entry_ttl_q[TABLE_SLOTS];

    t_presence_ack awaited_acks[$];
    int            fail_count = 0;

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string field, input logic [63:0] want,
                                   input logic [63:0] got);
        $display("%0t ns: mismatch on %s, expected 0x%0h, got 0x%0h", $time, field, want, got);
        fail_count++;
    endtask

    // Apply the request on the input ports to the shadow table and build its acknowledgement.
    task automatic apply_table_request(output t_presence_ack ack);
        int               i;
        int               hit;
        int               first_free;
        int               occ;
        int               onl;
        logic             chg;
        logic [TTL_W-1:0] ttl_eff;
        logic [TTL_W-1:0] t;
        ack        = '0;
        ack.status = STAT_OK;
        chg        = 1'b0;
        hit        = -1;
        first_free = -1;
        ttl_eff    = (ttl_reg != '0) ? ttl_reg : TTL_DEFAULT;
        if (i_req_type == REQ_SYNC) begin
            if (!i_well_formed || i_room_key == '0 || i_device_key == '0) begin
                ack.status = STAT_MALFORMED;
            end else begin
                // A key match wins; otherwise the lowest free slot is taken.
                for (i = 0; i < TABLE_SLOTS; i++) begin
                    if (!used_q[i]) begin
                        if (first_free < 0) first_free = i;
                    end else if (hit < 0 && room_q[i] == i_room_key) begin
                        hit = i;
                    end
                end
                if (hit < 0) hit = first_free;
                if (hit < 0) begin
                    ack.status = STAT_FULL;
                end else begin
                    chg = !used_q[hit] || dev_q[hit] != i_device_key ||
                          link_q[hit] != i_link_addr || online_q[hit] != i_online_in;
                    used_q[hit]      = 1'b1;
                    room_q[hit]      = i_room_key;
                    dev_q[hit]       = i_device_key;
                    link_q[hit]      = i_link_addr;
                    online_q[hit]    = i_online_in;
                    last_q[hit]      = i_now_ms;
                    entry_ttl_q[hit] = ttl_eff;
                    ack.ack_ok       = 1'b1;
                    ack.changed      = chg;
                    ack.slot_index   = OIDX_W'(hit);
                end
            end
        end else begin
            // Expire tick; an entry seen later than now never ages out.
            for (i = 0; i < TABLE_SLOTS; i++) begin
                if (used_q[i] && online_q[i]) begin
                    t = (entry_ttl_q[i] != '0) ? entry_ttl_q[i] : ttl_eff;
                    if (i_now_ms >= last_q[i] && (i_now_ms - last_q[i]) > TIME_W'(t)) begin
                        online_q[i] = 1'b0;
                        chg         = 1'b1;
                    end
                end
            end
            ack.changed = chg;
        end
        // Counts after the step, saturated to the field width.
        occ = 0;
        onl = 0;
        for (i = 0; i < TABLE_SLOTS; i++) begin
            if (used_q[i]) begin
                occ++;
                if (online_q[i]) onl++;
            end
        end
        ack.occupied_count = (occ > 31) ? OCNT_W'(31) : OCNT_W'(occ);
        ack.online_count   = (onl > 31) ? OCNT_W'(31) : OCNT_W'(onl);
    endtask

    // Observe transfers on every channel at each rising edge.
    always @(posedge i_clk) begin : watch_channels
        t_presence_ack want;
        int            i;
        if (!i_rst_n) begin
            ttl_reg = TTL_DEFAULT;
            for (i = 0; i < TABLE_SLOTS; i++) begin
                used_q[i]      = 1'b0;
                room_q[i]      = '0;
                dev_q[i]       = '0;
                link_q[i]      = '0;
                online_q[i]    = 1'b0;
                last_q[i]      = '0;
                entry_ttl_q[i] = '0;
            end
            awaited_acks.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                ttl_reg = i_cfg_ttl_ms;
            end
            // A reply transfer is matched against the oldest awaited acknowledgement.
            if (i_out_valid && i_out_ready) begin
                if (awaited_acks.size() == 0) begin
                    report_mismatch("reply with nothing awaited", '0,
                                    64'({i_ack_ok, i_status, i_changed, i_slot_index}));
                end else begin
                    want = awaited_acks.pop_front();
                    if (i_ack_ok !== want.ack_ok)
                        report_mismatch("ack_ok", 64'(want.ack_ok), 64'(i_ack_ok));
                    if (i_status !== want.status)
                        report_mismatch("status", 64'(want.status), 64'(i_status));
                    if (i_changed !== want.changed)
                        report_mismatch("changed", 64'(want.changed), 64'(i_changed));
                    if (i_slot_index !== want.slot_index)
                        report_mismatch("slot_index", 64'(want.slot_index),
                                        64'(i_slot_index));
                    if (i_occupied_count !== want.occupied_count)
                        report_mismatch("occupied_count", 64'(want.occupied_count),
                                        64'(i_occupied_count));
                    if (i_online_count !== want.online_count)
                        report_mismatch("online_count", 64'(want.online_count),
                                        64'(i_online_count));
                end
            end
            // A request transfer is predicted in the order the block accepts it.
            if (i_in_valid && i_in_ready) begin
                apply_table_request(want);
                awaited_acks.push_back(want);
            end
        end
        o_fail_count      <= fail_count;
        o_replies_pending <= awaited_acks.size();
    end

endmodule

### sim/tb_keyed_presence_table_with_aging_top.sv
// Testbench top for the keyed presence table: clock, reset, stimulus, handshakes and verdict.
`timescale 1ns / 1ps

module tb_keyed_presence_table_with_aging_top;
    import kpt_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = TABLE_SLOTS + 8;
    localparam int LONG_STALL   = 400;
    localparam int PHASE_ITEMS  = 130;
    localparam int PHASES       = 5;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_in_valid    = 1'b0;
    logic              o_in_ready;
    logic              i_req_type    = REQ_SYNC;
    logic              i_well_formed = 1'b0;
    logic [KEY_W-1:0]  i_room_key    = '0;
    logic [KEY_W-1:0]  i_device_key  = '0;
    logic [ADDR_W-1:0] i_link_addr   = '0;
    logic              i_online_in   = 1'b0;
    logic [TIME_W-1:0] i_now_ms      = '0;
    logic              o_out_valid;
    logic              i_out_ready   = 1'b0;
    logic              o_ack_ok;
    logic [1:0]        o_status;
    logic              o_changed;
    logic [OIDX_W-1:0] o_slot_index;
    logic [OCNT_W-1:0] o_occupied_count;
    logic [OCNT_W-1:0] o_online_count;
    logic              i_cfg_valid   = 1'b0;
    logic              o_cfg_ready;
    logic [TTL_W-1:0]  i_cfg_ttl_ms  = '0;

    int fail_count;
    int replies_pending;
    int cycle_count    = 0;
    int send_idle_pct  = 25;
    int recv_idle_pct  = 48;
    int stall_requests = 0;
    int stall_served   = 0;

    // Stimulus-side view of the TTL, used only to pace the time stamps.
    logic [TTL_W-1:0]  ttl_now = TTL_DEFAULT;
    logic [KEY_W-1:0]  room_pool[TABLE_SLOTS];
    logic [KEY_W-1:0]  pool_dev [TABLE_SLOTS];
    logic [ADDR_W-1:0] pool_link[TABLE_SLOTS];

    keyed_presence_table_with_aging_top DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_req_type       (i_req_type),
        .i_well_formed    (i_well_formed),
        .i_room_key       (i_room_key),
        .i_device_key     (i_device_key),
        .i_link_addr      (i_link_addr),
        .i_online_in      (i_online_in),
        .i_now_ms         (i_now_ms),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_ack_ok         (o_ack_ok),
        .o_status         (o_status),
        .o_changed        (o_changed),
        .o_slot_index     (o_slot_index),
        .o_occupied_count (o_occupied_count),
        .o_online_count   (o_online_count),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_ttl_ms     (i_cfg_ttl_ms)
    );

    presence_table_checker u_presence_table_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_ready        (o_in_ready),
        .i_req_type        (i_req_type),
        .i_well_formed     (i_well_formed),
        .i_room_key        (i_room_key),
        .i_device_key      (i_device_key),
        .i_link_addr       (i_link_addr),
        .i_online_in       (i_online_in),
        .i_now_ms          (i_now_ms),
        .i_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .i_ack_ok          (o_ack_ok),
        .i_status          (o_status),
        .i_changed         (o_changed),
        .i_slot_index      (o_slot_index),
        .i_occupied_count  (o_occupied_count),
        .i_online_count    (o_online_count),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_ttl_ms      (i_cfg_ttl_ms),
        .o_fail_count      (fail_count),
        .o_replies_pending (replies_pending)
    );

    // 20 ns clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Run-length guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Reply side: random back-pressure, or a long hold-off when one is requested.
    initial begin
        forever begin
            @(posedge i_clk);
            if (stall_requests != stall_served) begin
                i_out_ready <= 1'b0;
                repeat (LONG_STALL - 1) @(posedge i_clk);
                stall_served++;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offer one request after a random gap and hold it until the transfer.
    task automatic send_request(input logic rtype, input logic wf,
                                input logic [KEY_W-1:0] room, input logic [KEY_W-1:0] dev,
                                input logic [ADDR_W-1:0] link, input logic onl,
                                input logic [TIME_W-1:0] now);
        int gap;
        gap = 0;
        while (gap < 12 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_req_type    <= rtype;
        i_well_formed <= wf;
        i_room_key    <= room;
        i_device_key  <= dev;
        i_link_addr   <= link;
        i_online_in   <= onl;
        i_now_ms      <= now;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Drop the request valid and wait until every awaited reply has come back.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (replies_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write the TTL register while the block is idle.
    task automatic write_ttl(input logic [TTL_W-1:0] value);
        wait_drained();
        i_cfg_valid  <= 1'b1;
        i_cfg_ttl_ms <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        ttl_now = value;
    endtask

    // Main stimulus and verdict.
    initial begin
        logic [TTL_W-1:0]  ttl_plan[PHASES];
        logic [TTL_W-1:0]  ttl_eff;
        logic [TIME_W-1:0] stamp_ms;
        logic [KEY_W-1:0]  room;
        logic [KEY_W-1:0]  dev;
        logic [ADDR_W-1:0] link;
        logic              wf;
        int                phase;
        int                n;
        int                k;
        int                roll;
        int                pick;

        // Pool of room keys, the extremes among them, plus device data per key.
        room_pool[0] = 64'h1;
        room_pool[1] = '1;
        room_pool[2] = 64'h8000_0000_0000_0000;
        for (k = 3; k < TABLE_SLOTS; k++) room_pool[k] = {$urandom, $urandom} | 64'h1;
        for (k = 0; k < TABLE_SLOTS; k++) begin
            pool_dev[k]  = {$urandom, $urandom} | 64'h1;
            pool_link[k] = $urandom;
        end
        ttl_plan[0] = 32'd1;
        ttl_plan[1] = '1;
        ttl_plan[2] = '0;
        ttl_plan[3] = $urandom_range(32'd5000, 32'd2);
        ttl_plan[4] = TTL_DEFAULT;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, at the reset TTL: empty table, malformed forms, slot reuse,
        // time running backwards, the exact TTL boundary, and a full table.
        send_request(REQ_EXPIRE, 1'b0, '0, '0, '0, 1'b0, '0);
        send_request(REQ_SYNC, 1'b0, room_pool[0], 64'h5, 32'h1, 1'b1, 48'd10);
        send_request(REQ_SYNC, 1'b1, '0, 64'h5, 32'h1, 1'b1, 48'd10);
        send_request(REQ_SYNC, 1'b1, room_pool[0], '0, 32'h1, 1'b1, 48'd10);
        send_request(REQ_SYNC, 1'b1, room_pool[0], '1, '1, 1'b1, '0);
        send_request(REQ_SYNC, 1'b1, room_pool[0], '1, '1, 1'b1, '0);
        send_request(REQ_SYNC, 1'b1, room_pool[0], '1, '1, 1'b0, '0);
        send_request(REQ_SYNC, 1'b1, room_pool[1], 64'h1, '0, 1'b1, '1);
        send_request(REQ_EXPIRE, 1'b1, '1, '1, '1, 1'b1, '0);
        send_request(REQ_SYNC, 1'b1, room_pool[2], pool_dev[2], pool_link[2], 1'b1, 48'd1000);
        send_request(REQ_EXPIRE, 1'b0, '0, '0, '0, 1'b0, 48'd31000);
        send_request(REQ_EXPIRE, 1'b0, '0, '0, '0, 1'b0, 48'd31001);
        for (k = 3; k < TABLE_SLOTS; k++)
            send_request(REQ_SYNC, 1'b1, room_pool[k], pool_dev[k], pool_link[k], 1'b1,
                         48'd32000);
        send_request(REQ_SYNC, 1'b1, 64'h0123_4567_89ab_cdef, 64'h7, 32'h7, 1'b1, 48'd32001);

        // Random phases, each at its own TTL and idling pattern.
        stamp_ms = 48'd40000;
        for (phase = 0; phase < PHASES; phase++) begin
            write_ttl(ttl_plan[phase]);
            send_idle_pct = (phase < 2) ? 25 : (phase < 4) ? 48 : 0;
            recv_idle_pct = (phase < 2) ? 48 : (phase < 4) ? 25 : 0;
            if (phase == 1 || phase == 3) stall_requests++;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                ttl_eff = (ttl_now != '0) ? ttl_now : TTL_DEFAULT;
                // Time mostly moves forward, sometimes back, rarely jumps anywhere.
                roll = $urandom_range(99);
                stamp_ms = stamp_ms + $urandom_range((ttl_eff >> 2) + 32'd3, 0);
                if (roll < 3)
                    stamp_ms = TIME_W'({$urandom, $urandom});
                else if (roll < 8 && stamp_ms > TIME_W'(ttl_eff))
                    stamp_ms = stamp_ms - $urandom_range(ttl_eff, 0);

                roll = $urandom_range(99);
                if (roll < 20) begin
                    // Expire tick; the other fields carry noise.
                    send_request(REQ_EXPIRE, 1'($urandom), {$urandom, $urandom},
                                 {$urandom, $urandom}, $urandom, 1'($urandom), stamp_ms);
                end else begin
                    pick = $urandom_range(TABLE_SLOTS - 1);
                    room = (roll < 85) ? room_pool[pick] : {$urandom, $urandom};
                    // Reusing the device data yields syncs that change nothing.
                    if ($urandom_range(99) < 40) begin
                        pool_dev[pick]  = {$urandom, $urandom};
                        pool_link[pick] = $urandom;
                    end
                    dev  = pool_dev[pick];
                    link = pool_link[pick];
                    wf   = 1'b1;
                    roll = $urandom_range(99);
                    if (roll < 4) wf = 1'b0;
                    else if (roll < 7) room = '0;
                    else if (roll < 10) dev = '0;
                    send_request(REQ_SYNC, wf, room, dev, link, 1'($urandom), stamp_ms);
                end
            end
        end

        wait_drained();
        if (fail_count == 0 && replies_pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### sim.f
rtl/kpt_pkg.sv
rtl/kpt_store.sv
rtl/kpt_slot_unit.sv
rtl/keyed_presence_table_with_aging_top.sv
sim/presence_table_checker.sv
sim/tb_keyed_presence_table_with_aging_top.sv
